// ===== design/phdm_pkg.sv =====
package phdm_pkg;

	// Field widths of the meter transaction.
	localparam int unsigned RDG_W   = 21;
	localparam int unsigned ALC_W   = 18;
	localparam int unsigned PWR_W   = 20;
	localparam int unsigned HOLD_W  = 4;
	localparam int unsigned CNT_W   = 5;
	localparam int unsigned DECAY_W = RDG_W + 3;

	// Field limits and peak floors, in 1/1024 units.
	localparam logic signed [RDG_W-1:0] RX_FLOOR  = -21'sd204800;
	localparam logic signed [RDG_W-1:0] RDG_CEIL  = 21'sd1024000;
	localparam logic signed [RDG_W-1:0] PWR_FLOOR = 21'sd0;
	localparam logic signed [ALC_W-1:0] ALC_FLOOR = -18'sd102400;
	localparam logic signed [ALC_W-1:0] ALC_CEIL  = 18'sd30720;

	localparam logic [HOLD_W-1:0] HOLD_RESET = 4'd5;
	localparam logic [CNT_W-1:0]  CNT_LIMIT  = 5'd31;

	// Meter modes.
	localparam logic MODE_RX = 1'b0;
	localparam logic MODE_TX = 1'b1;

	// Held meter state, shared by the update logic and the state register.
	typedef struct packed {
		logic                    last_mode;
		logic signed [RDG_W-1:0] peak_rx;
		logic signed [RDG_W-1:0] peak_power;
		logic signed [ALC_W-1:0] peak_alc;
		logic [CNT_W-1:0]        hold_counter;
	} phdm_state_t;

	localparam phdm_state_t STATE_RESET = '{
		last_mode:    MODE_RX,
		peak_rx:      RX_FLOOR,
		peak_power:   PWR_FLOOR,
		peak_alc:     ALC_FLOOR,
		hold_counter: '0
	};

	// floor((3*p + x) / 4), clamped at fl. The arithmetic shift rounds toward
	// minus infinity, and the result never exceeds the larger of p and x.
	function automatic logic signed [RDG_W-1:0] decay(
		input logic signed [RDG_W-1:0] p,
		input logic signed [RDG_W-1:0] x,
		input logic signed [RDG_W-1:0] fl
	);
		logic signed [DECAY_W-1:0] pe;
		logic signed [DECAY_W-1:0] t;
		logic signed [DECAY_W-1:0] s;
		pe = DECAY_W'(p);
		t  = (pe <<< 1) + pe + DECAY_W'(x);
		s  = t >>> 2;
		if (s < DECAY_W'(fl)) begin
			return fl;
		end
		return s[RDG_W-1:0];
	endfunction

endpackage

// ===== design/phdm_update.sv =====
module phdm_update (
	input  logic                              meter_mode,
	input  logic signed [phdm_pkg::RDG_W-1:0] reading,
	input  logic signed [phdm_pkg::ALC_W-1:0] alc_level,
	input  logic [phdm_pkg::HOLD_W-1:0]       hold_updates,
	input  phdm_pkg::phdm_state_t             cur,
	output phdm_pkg::phdm_state_t             nxt
);
	import phdm_pkg::*;

	logic signed [RDG_W-1:0] val;
	logic signed [ALC_W-1:0] alc;
	logic signed [RDG_W-1:0] alc_ext;
	logic signed [RDG_W-1:0] alc_dec;
	phdm_state_t             base;
	logic                    decaying;
	logic                    restart;
	logic [CNT_W-1:0]        cnt;

	// Saturate the inputs to their field ranges.
	always_comb begin
		if (reading < RX_FLOOR) begin
			val = RX_FLOOR;
		end else if (reading > RDG_CEIL) begin
			val = RDG_CEIL;
		end else begin
			val = reading;
		end
		if (alc_level < ALC_FLOOR) begin
			alc = ALC_FLOOR;
		end else if (alc_level > ALC_CEIL) begin
			alc = ALC_CEIL;
		end else begin
			alc = alc_level;
		end
	end

	// A mode change returns every peak to its floor and restarts the hold.
	always_comb begin
		base = cur;
		if (meter_mode != cur.last_mode) begin
			base           = STATE_RESET;
			base.last_mode = meter_mode;
		end
	end

	assign decaying = base.hold_counter > CNT_W'(hold_updates);
	assign alc_ext  = RDG_W'(base.peak_alc);
	assign alc_dec  = decay(alc_ext, RDG_W'(alc), RDG_W'(ALC_FLOOR));

	// Decay the active peaks, then take any new peak from the input.
	always_comb begin
		nxt     = base;
		restart = 1'b0;
		if (meter_mode == MODE_TX) begin
			if (decaying) begin
				nxt.peak_power = decay(base.peak_power, val, PWR_FLOOR);
				nxt.peak_alc   = alc_dec[ALC_W-1:0];
			end
			if (val > nxt.peak_power) begin
				nxt.peak_power = val;
				restart        = 1'b1;
			end
			if (alc > nxt.peak_alc) begin
				nxt.peak_alc = alc;
				restart      = 1'b1;
			end
		end else begin
			if (decaying) begin
				nxt.peak_rx = decay(base.peak_rx, val, RX_FLOOR);
			end
			if (val > nxt.peak_rx) begin
				nxt.peak_rx = val;
				restart     = 1'b1;
			end
		end

		// The hold counter counts updates and saturates at its limit.
		cnt = restart ? '0 : base.hold_counter;
		if (cnt < CNT_LIMIT) begin
			cnt = cnt + CNT_W'(1);
		end
		nxt.hold_counter = cnt;
	end

endmodule

// ===== design/peak_hold_decay_meter.sv =====
// Peak hold meter with exponential decay.
// Input channel (in_valid/in_ready) carries one meter reading per transaction:
// meter_mode, reading and alc_level. Output channel (out_valid/out_ready)
// returns one transaction per reading with the three held peaks.
// A reading is captured in an input register, updated against the held state
// by combinational logic, and moved to the output register once it is free.
// Throughput is one reading per cycle while the receiver does not stall; the
// update of the held peaks and the hold counter is combinational, so each
// reading sees the state left by the one before it with no bubble. When the
// receiver stalls, the result waits in the output register and one more
// reading is still taken into the input register; in_ready then drops until
// the output drains. The hold count is written through cfg_wr_en/cfg_wr_data;
// the user must write it only while the meter is idle, and the block itself
// does not enforce this. Reset (arst_n low) empties both registers, sets the
// hold count to 5, selects receive mode and returns every peak to its floor.
module peak_hold_decay_meter (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [phdm_pkg::HOLD_W-1:0]        cfg_wr_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               meter_mode,
	input  logic signed [phdm_pkg::RDG_W-1:0]  reading,
	input  logic signed [phdm_pkg::ALC_W-1:0]  alc_level,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [phdm_pkg::RDG_W-1:0]  held_rx_level,
	output logic [phdm_pkg::PWR_W-1:0]         held_power,
	output logic signed [phdm_pkg::ALC_W-1:0]  held_alc
);
	import phdm_pkg::*;

	logic [HOLD_W-1:0]       hold_q;
	logic                    valid_s1;
	logic                    mode_s1;
	logic signed [RDG_W-1:0] reading_s1;
	logic signed [ALC_W-1:0] alc_s1;
	phdm_state_t             state_q;
	phdm_state_t             state_nxt;
	logic                    out_valid_q;
	logic signed [RDG_W-1:0] held_rx_q;
	logic signed [RDG_W-1:0] held_power_q;
	logic signed [ALC_W-1:0] held_alc_q;
	logic                    out_free;
	logic                    advance;

	assign out_free = !out_valid_q || out_ready;
	assign advance  = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	// Hold count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= HOLD_RESET;
		end else if (cfg_wr_en) begin
			hold_q <= cfg_wr_data;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_s1    <= meter_mode;
			reading_s1 <= reading;
			alc_s1     <= alc_level;
		end
	end

	// Peak and hold counter update.
	phdm_update u_update (
		.meter_mode   (mode_s1),
		.reading      (reading_s1),
		.alc_level    (alc_s1),
		.hold_updates (hold_q),
		.cur          (state_q),
		.nxt          (state_nxt)
	);

	// Held state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			held_rx_q    <= state_nxt.peak_rx;
			held_power_q <= state_nxt.peak_power;
			held_alc_q   <= state_nxt.peak_alc;
		end
	end

	assign out_valid     = out_valid_q;
	assign held_rx_level = held_rx_q;
	assign held_power    = held_power_q[PWR_W-1:0];
	assign held_alc      = held_alc_q;

	// The held peaks never fall below their floors.
	a_power_floor: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.peak_power >= PWR_FLOOR)
		else $error("held power peak below its floor");

	a_rx_floor: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.peak_rx >= RX_FLOOR && state_q.peak_alc >= ALC_FLOOR)
		else $error("held rx or ALC peak below its floor");

	// A reading that cannot move on keeps its place in the input register.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_free |=> valid_s1 && $stable(reading_s1) && $stable(state_q))
		else $error("stalled reading lost or state changed");

	// Every update leaves the hold counter above zero.
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> state_q.hold_counter != '0)
		else $error("hold counter zero after an update");

endmodule
